// File: design/bilinear_image_scaler_core_macros.svh
// assertion helpers shared by the scaler modules
`ifndef BILINEAR_IMAGE_SCALER_CORE_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BISC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bisc assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BISC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bisc assertion failed");

`endif

// File: design/bisc_pkg.sv
`default_nettype none

package bisc_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int SWW = $clog2(MAX_WIDTH + 1);
	localparam int SHW = $clog2(MAX_HEIGHT + 1);
	localparam int SMW = (SWW > SHW) ? SWW : SHW;

	// fixed point: 16 fraction bits, weights run 0 to 1.0 inclusive
	localparam int FRAC = 16;
	localparam int WTW = FRAC + 1;
	localparam int ONE = 1 << FRAC;
	localparam int HALF = 1 << (FRAC - 1);

	// (2d+1)*size, then shifted up by the fraction bits
	localparam int AXW = 9 + SMW;
	localparam int NW = AXW + FRAC;
	// divisor is 2*dst, dst up to 511
	localparam int DVW = 10;
	localparam int REMW = DVW + 1;
	// quotient bits resolved per divider stage
	localparam int DK = 4;
	localparam int DS = (NW + DK - 1) / DK;
	localparam int NPW = DS * DK;

	localparam int QD = 4;
	localparam int QAW = $clog2(QD);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CALC = 1'b1;
	localparam logic [2:0] CHAN_RGB = 3'd3;

	typedef enum logic [2:0] {
		REG_SRC_W = 3'd0,
		REG_SRC_H = 3'd1,
		REG_DST_W = 3'd2,
		REG_DST_H = 3'd3,
		REG_CHAN  = 3'd4
	} reg_idx_t;

	typedef enum logic {
		B_IDLE,
		B_READ
	} bst_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} res_t;

	typedef struct packed {
		logic [8:0] src_w;
		logic [8:0] src_h;
		logic [8:0] dst_w;
		logic [8:0] dst_h;
		logic [2:0] chan;
	} cfg_t;

	// one classified item on its way to the back end
	typedef struct packed {
		logic           is_load;
		logic [AW-1:0]  addr;
		logic [31:0]    pix;
		logic [XW-1:0]  bx;
		logic [XW-1:0]  nx;
		logic [YW-1:0]  by;
		logic [YW-1:0]  ny;
		logic [WTW-1:0] wx;
		logic [WTW-1:0] wy;
	} cmd_t;

	// zero acts as one, anything above cap acts as cap
	function automatic logic [15:0] eff_size(input logic [8:0] v, input int unsigned cap);
		logic [15:0] r;
		if (v == 9'd0) begin
			r = 16'd1;
		end else if (32'(v) > cap) begin
			r = 16'(cap);
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/bisc_div.sv
`default_nettype none

module bisc_div import bisc_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [NW-1:0]   numer,
	input  logic [DVW-1:0]  dvs,
	output logic [NW-1:0]   quot
);

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [DK-1:0]   qb;
	} step_t;

	logic [REMW-1:0] rem_sk [DS];
	logic [NPW-1:0]  num_sk [DS];
	logic [NPW-1:0]  quo_sk [DS];

	logic [REMW-1:0] rem_d [DS];
	logic [NPW-1:0]  num_d [DS];
	logic [NPW-1:0]  quo_d [DS];

	// restoring division, DK bits at a time
	function automatic step_t div_step(input logic [REMW-1:0] r_in,
			input logic [DK-1:0] bits, input logic [DVW-1:0] d);
		logic [REMW-1:0] r;
		step_t o;
		r = r_in;
		o.qb = '0;
		for (int k = DK - 1; k >= 0; k--) begin
			r = {r[REMW-2:0], bits[k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				o.qb[k] = 1'b1;
			end
		end
		o.rem = r;
		return o;
	endfunction

	always_comb begin
		step_t st;
		logic [REMW-1:0] r_prev;
		logic [NPW-1:0] n_prev;
		logic [NPW-1:0] q_prev;
		for (int j = 0; j < DS; j++) begin
			if (j == 0) begin
				r_prev = '0;
				n_prev = NPW'(numer);
				q_prev = '0;
			end else begin
				r_prev = rem_sk[j-1];
				n_prev = num_sk[j-1];
				q_prev = quo_sk[j-1];
			end
			st = div_step(r_prev, n_prev[NPW-1 -: DK], dvs);
			rem_d[j] = st.rem;
			num_d[j] = n_prev << DK;
			quo_d[j] = {q_prev[NPW-DK-1:0], st.qb};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DS; j++) begin
				rem_sk[j] <= rem_d[j];
				num_sk[j] <= num_d[j];
				quo_sk[j] <= quo_d[j];
			end
		end
	end

	assign quot = quo_sk[DS-1][NW-1:0];

endmodule

`default_nettype wire

// File: design/bisc_front.sv
`default_nettype none

module bisc_front import bisc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  push_valid,
	input  logic  push_ready,
	output cmd_t  push
);

	localparam int IBW = NW - FRAC;

	typedef struct packed {
		logic [15:0]    base;
		logic [15:0]    nbr;
		logic [WTW-1:0] wt;
	} axis_t;

	logic [SWW-1:0] sw_c;
	logic [SHW-1:0] sh_c;
	logic [DVW-1:0] dvx_c;
	logic [DVW-1:0] dvy_c;
	logic [AXW-1:0] ax_c;
	logic [AXW-1:0] ay_c;
	logic [NW-1:0]  num_x_s1;
	logic [NW-1:0]  num_y_s1;
	logic [NW-1:0]  quo_x;
	logic [NW-1:0]  quo_y;
	logic           vld_sk [DS+1];
	req_t           item_sk [DS+1];
	logic           adv;
	logic           load_ok;
	logic           keep;
	axis_t          map_x;
	axis_t          map_y;
	req_t           last;

	// center-aligned source coordinate to base, neighbor and weight
	function automatic axis_t map_axis(input logic [NW-1:0] q, input logic [15:0] size);
		logic [NW-1:0] s;
		logic [IBW-1:0] ib;
		axis_t r;
		s = q - NW'(HALF);
		ib = s[NW-1:FRAC];
		if (q < NW'(HALF)) begin
			r.base = '0;
			r.wt = '0;
		end else if (32'(ib) > 32'(size) - 32'd1) begin
			r.base = size - 16'd1;
			r.wt = WTW'(ONE);
		end else begin
			r.base = 16'(ib);
			r.wt = {1'b0, s[FRAC-1:0]};
		end
		r.nbr = (r.base == size - 16'd1) ? r.base : r.base + 16'd1;
		return r;
	endfunction

	assign sw_c = SWW'(eff_size(cfg.src_w, MAX_WIDTH));
	assign sh_c = SHW'(eff_size(cfg.src_h, MAX_HEIGHT));
	assign dvx_c = {((cfg.dst_w == 9'd0) ? 9'd1 : cfg.dst_w), 1'b0};
	assign dvy_c = {((cfg.dst_h == 9'd0) ? 9'd1 : cfg.dst_h), 1'b0};

	assign ax_c = AXW'({req.pos_x, 1'b1}) * AXW'(sw_c);
	assign ay_c = AXW'({req.pos_y, 1'b1}) * AXW'(sh_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DS; i++) begin
				vld_sk[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_sk[0] <= req_valid;
			for (int i = 1; i <= DS; i++) begin
				vld_sk[i] <= vld_sk[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_sk[0] <= req;
			num_x_s1 <= {ax_c, {FRAC{1'b0}}};
			num_y_s1 <= {ay_c, {FRAC{1'b0}}};
			for (int i = 1; i <= DS; i++) begin
				item_sk[i] <= item_sk[i-1];
			end
		end
	end

	bisc_div u_div_x (
		.clk   (clk),
		.en    (adv),
		.numer (num_x_s1),
		.dvs   (dvx_c),
		.quot  (quo_x)
	);

	bisc_div u_div_y (
		.clk   (clk),
		.en    (adv),
		.numer (num_y_s1),
		.dvs   (dvy_c),
		.quot  (quo_y)
	);

	assign last = item_sk[DS];
	assign map_x = map_axis(quo_x, 16'(sw_c));
	assign map_y = map_axis(quo_y, 16'(sh_c));

	// loads outside the store are dropped here
	assign load_ok = (32'(last.pos_x) < MAX_WIDTH) && (32'(last.pos_y) < MAX_HEIGHT);
	assign keep = (last.req_type == REQ_CALC) || load_ok;

	assign push_valid = vld_sk[DS] && keep;
	assign adv = !(push_valid && !push_ready);
	assign req_ready = adv;

	always_comb begin
		push.is_load = (last.req_type == REQ_LOAD);
		push.addr = {YW'(last.pos_y), XW'(last.pos_x)};
		push.pix = {last.in_alpha, last.in_blue, last.in_green, last.in_red};
		push.bx = XW'(map_x.base);
		push.nx = XW'(map_x.nbr);
		push.by = YW'(map_y.base);
		push.ny = YW'(map_y.nbr);
		push.wx = map_x.wt;
		push.wy = map_y.wt;
	end

endmodule

`default_nettype wire

// File: design/bisc_queue.sv
`default_nettype none

module bisc_queue import bisc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  cmd_t  push,
	output logic  pop_valid,
	input  logic  pop_ready,
	output cmd_t  pop
);

`include "bilinear_image_scaler_core_macros.svh"

	cmd_t           mem_q [QD];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != (QAW+1)'(QD));
	assign pop_valid = (cnt_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push;
		end
	end

	`BISC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (QAW+1)'(QD))
	`BISC_ASSERT_IMP(a_ptr_track, 1'b1, wr_q == QAW'(rd_q + cnt_q[QAW-1:0]))
	`BISC_ASSERT_NXT(a_fill_step, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

// File: design/bisc_back.sv
`default_nettype none

module bisc_back import bisc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  chan,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cmd_t        pop,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

`include "bilinear_image_scaler_core_macros.svh"

	localparam int TOPW = 24;
	localparam int TOTW = 41;

	bst_t           state_q;
	bst_t           state_d;
	logic [1:0]     cnt_q;
	logic [1:0]     cnt_d;
	cmd_t           cmd_q;
	logic           take_cmd;

	logic [31:0]    frame_q [2**AW];
	logic           wr_en;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [1:0]     rd_idx;
	logic [31:0]    rd_data_q;
	logic           rd_vld_s1;
	logic [1:0]     rd_idx_s1;
	logic           rd_last;

	logic [31:0]    pix0_q;
	logic [31:0]    pix1_q;
	logic [31:0]    pix2_q;

	logic           vld_s2;
	logic [31:0]    pix_s2 [4];
	logic [WTW-1:0] wx_s2;
	logic [WTW-1:0] wy_s2;

	logic           vld_s3;
	logic [TOPW-1:0] top_s3 [4];
	logic [TOPW-1:0] bot_s3 [4];
	logic [WTW-1:0] wy_s3;

	logic           vld_s4;
	res_t           res_s4;

	logic           adv;
	logic [TOPW-1:0] top_c [4];
	logic [TOPW-1:0] bot_c [4];
	logic [7:0]     val_c [4];

	assign adv = !vld_s4 || res_ready;

	// fetch sequencer: one frame access per cycle, holding the last read while the gather stage is full
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pop_ready = 1'b0;
		take_cmd = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		rd_idx = cnt_q;
		rd_addr = {pop.by, pop.bx};
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				rd_idx = 2'd0;
				if (pop_valid) begin
					if (pop.is_load) begin
						wr_en = 1'b1;
					end else begin
						take_cmd = 1'b1;
						rd_en = 1'b1;
						cnt_d = 2'd1;
						state_d = B_READ;
					end
				end
			end
			B_READ: begin
				case (cnt_q)
					2'd1: rd_addr = {cmd_q.by, cmd_q.nx};
					2'd2: rd_addr = {cmd_q.ny, cmd_q.bx};
					default: rd_addr = {cmd_q.ny, cmd_q.nx};
				endcase
				if (cnt_q == 2'd3) begin
					// last read only when the gather stage can take it
					if (!vld_s2 || adv) begin
						rd_en = 1'b1;
						state_d = B_IDLE;
					end
				end else begin
					rd_en = 1'b1;
					cnt_d = cnt_q + 2'd1;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= 2'd0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= 2'd0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= rd_idx;
			if (rd_last) begin
				vld_s2 <= 1'b1;
			end else if (adv) begin
				vld_s2 <= 1'b0;
			end
			if (adv) begin
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			cmd_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_q[pop.addr] <= pop.pix;
		end
		if (rd_en) begin
			rd_data_q <= frame_q[rd_addr];
		end
	end

	assign rd_last = rd_vld_s1 && (rd_idx_s1 == 2'd3);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			case (rd_idx_s1)
				2'd0: pix0_q <= rd_data_q;
				2'd1: pix1_q <= rd_data_q;
				2'd2: pix2_q <= rd_data_q;
				default: ;
			endcase
		end
		if (rd_last) begin
			pix_s2[0] <= pix0_q;
			pix_s2[1] <= pix1_q;
			pix_s2[2] <= pix2_q;
			pix_s2[3] <= rd_data_q;
			wx_s2 <= cmd_q.wx;
			wy_s2 <= cmd_q.wy;
		end
	end

	// horizontal blend of both rows
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			top_c[c] = TOPW'((WTW'(ONE) - wx_s2) * pix_s2[0][8*c +: 8]
				+ wx_s2 * pix_s2[1][8*c +: 8]);
			bot_c[c] = TOPW'((WTW'(ONE) - wx_s2) * pix_s2[2][8*c +: 8]
				+ wx_s2 * pix_s2[3][8*c +: 8]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				top_s3[c] <= top_c[c];
				bot_s3[c] <= bot_c[c];
			end
			wy_s3 <= wy_s2;
		end
	end

	// vertical blend, round half up
	always_comb begin
		logic [TOTW-1:0] tot;
		for (int c = 0; c < 4; c++) begin
			tot = TOTW'(WTW'(ONE) - wy_s3) * TOTW'(top_s3[c])
				+ TOTW'(wy_s3) * TOTW'(bot_s3[c])
				+ (TOTW'(1) << (2 * FRAC - 1));
			val_c[c] = tot[2*FRAC +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4.out_red <= val_c[0];
			res_s4.out_green <= val_c[1];
			res_s4.out_blue <= val_c[2];
			res_s4.out_alpha <= (chan == CHAN_RGB) ? 8'd0 : val_c[3];
		end
	end

	assign res_valid = vld_s4;
	assign res = res_s4;

	`BISC_ASSERT_IMP(a_gather_free, rd_last, !vld_s2)
	`BISC_ASSERT_NXT(a_gather_hold, vld_s2 && !adv, vld_s2)
	`BISC_ASSERT_IMP(a_first_read, rd_vld_s1 && (rd_idx_s1 == 2'd0), state_q == B_READ)

endmodule

`default_nettype wire

// File: design/bilinear_image_scaler_core.sv
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+------------------------------------
// config   | cfg_valid | cfg_ready | cfg_index, cfg_data (always ready)
// request  | req_valid | req_ready | req  (load pixel or compute pixel)
// result   | res_valid | res_ready | res  (one per compute request)
//
// front end takes a request every cycle unless the queue is full; per axis it multiplies
// and runs a pipelined divider that resolves four quotient bits per stage
// a compute request makes four neighbor reads in the back end, one after another
// on the single-ported frame store before it takes the next item; a load makes one write
// a four-entry queue separates the two, so the front keeps taking requests
// while the back reads; a full queue stalls the whole front pipeline
// arst_n clears control state only; frame contents are undefined until loaded
`default_nettype none

module bilinear_image_scaler_core import bisc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	cfg_t cfg_q;

	logic push_valid;
	logic push_ready;
	cmd_t push;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop;

	// the user must change config only while idle (the block does not enforce this), so both halves read it live
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_w <= 9'd256;
			cfg_q.src_h <= 9'd256;
			cfg_q.dst_w <= 9'd256;
			cfg_q.dst_h <= 9'd256;
			cfg_q.chan <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			// unknown indexes fall through and are dropped
			unique case (cfg_index)
				REG_SRC_W: cfg_q.src_w <= cfg_data;
				REG_SRC_H: cfg_q.src_h <= cfg_data;
				REG_DST_W: cfg_q.dst_w <= cfg_data;
				REG_DST_H: cfg_q.dst_h <= cfg_data;
				REG_CHAN:  cfg_q.chan <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// coordinate mapping: classify, multiply, divide, clamp
	bisc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push)
	);

	// decoupling queue between mapping and frame access
	bisc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop        (pop)
	);

	// frame store, neighbor fetch, blend and result register
	bisc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.chan      (cfg_q.chan),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

`default_nettype wire
